FILE: design/bfha_pkg.sv
package bfha_pkg;

    localparam int ARENA_BYTES = 65536;
    localparam int HDR_BYTES   = 16;
    localparam int IDX_W       = 14;
    localparam int DEPTH       = 1 << IDX_W;
    localparam int SZ_W        = 16;
    localparam int REQ_W       = 17;
    localparam int OFS_W       = 16;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_RESIZE = 2'd2,
        OP_INIT   = 2'd3
    } t_op;

    typedef struct packed {
        logic [SZ_W-1:0]  size;
        logic             used;
        logic [IDX_W-1:0] prev;
        logic             has_prev;
        logic [IDX_W-1:0] next;
        logic             has_next;
    } t_hdr;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_hdr             wdata;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic             status;
        logic [OFS_W-1:0] result_offset;
        logic             moved;
        logic [SZ_W-1:0]  copy_bytes;
    } t_res;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WALK,
        S_AL_ST,
        S_AL_LD,
        S_RZ_N,
        S_RZ_P,
        S_FR_B,
        S_FR_P,
        S_FR_NX,
        S_FR_N,
        S_FR_WR,
        S_SPL,
        S_SPL_F,
        S_SPL_WN,
        S_SP_WR,
        S_INIT,
        S_CONT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        C_DONE,
        C_ALLOC,
        C_FREE
    } t_cont;

    function automatic logic [REQ_W-1:0] round_size(input logic [OFS_W-1:0] r);
        logic [REQ_W-1:0] s;
        s = {1'b0, r} + REQ_W'(3);
        return {s[REQ_W-1:2], 2'b00};
    endfunction

endpackage

FILE: design/bfha_req_if.sv
interface bfha_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  operation;
    logic [bfha_pkg::OFS_W-1:0]  payload_offset;
    logic [bfha_pkg::OFS_W-1:0]  request_bytes;

    modport source (output valid, operation, payload_offset, request_bytes, input ready);
    modport sink   (input valid, operation, payload_offset, request_bytes, output ready);
endinterface

FILE: design/bfha_rsp_if.sv
interface bfha_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic [bfha_pkg::OFS_W-1:0]  result_offset;
    logic                        moved;
    logic [bfha_pkg::SZ_W-1:0]   copy_bytes;

    modport source (output valid, status, result_offset, moved, copy_bytes, input ready);
    modport sink   (input valid, status, result_offset, moved, copy_bytes, output ready);
endinterface

FILE: design/bfha_cfg_if.sv
interface bfha_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [bfha_pkg::REQ_W-1:0]  arena_bytes;

    modport source (output valid, arena_bytes, input ready);
    modport sink   (input valid, arena_bytes, output ready);
endinterface

FILE: design/bfha_hdr_mem.sv
module bfha_hdr_mem (
    input  logic               i_clk,
    input  bfha_pkg::t_mem_req i_req,
    output bfha_pkg::t_hdr     o_q
);
    import bfha_pkg::*;

    t_hdr r_mem [DEPTH];
    t_hdr r_q;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_q <= r_mem[i_req.raddr];
    end

    assign o_q = r_q;

endmodule

FILE: design/bfha_seq.sv
module bfha_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  bfha_pkg::t_op               i_op,
    input  logic [bfha_pkg::OFS_W-1:0]  i_ptr,
    input  logic [bfha_pkg::OFS_W-1:0]  i_req,
    input  logic [bfha_pkg::REQ_W-1:0]  i_arena,
    output bfha_pkg::t_mem_req          o_mem,
    input  bfha_pkg::t_hdr              i_q,
    output logic                        o_done,
    output bfha_pkg::t_res              o_res,
    input  logic                        i_out_free
);
    import bfha_pkg::*;

    t_state           r_st, n_st;
    t_state           r_spret, n_spret;
    t_cont            r_cont, n_cont;
    t_op              r_op, n_op;
    logic [OFS_W-1:0] r_ptr, n_ptr;
    logic [REQ_W-1:0] r_sz, n_sz;
    logic [IDX_W-1:0] r_b, n_b;
    logic [IDX_W-1:0] r_own, n_own;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_x, n_x;
    logic [IDX_W-1:0] r_best, n_best;
    logic [IDX_W-1:0] r_spa, n_spa;
    logic [IDX_W-1:0] r_spv, n_spv;
    logic [SZ_W-1:0]  r_bsz, n_bsz;
    logic [SZ_W-1:0]  r_old, n_old;
    logic             r_found, n_found;
    logic             r_lookup, n_lookup;
    logic             r_move, n_move;
    t_hdr             r_hb, n_hb;
    t_hdr             r_hx, n_hx;
    t_res             r_res, n_res;

    logic [REQ_W-1:0] eff;
    logic [REQ_W-1:0] init_sz;
    logic [REQ_W-1:0] rem;
    logic [REQ_W:0]   nw;
    logic [REQ_W:0]   sum;
    logic             cand;
    logic             nf;
    logic [IDX_W-1:0] nb;
    t_hdr             h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            r_st <= n_st;
        end
        r_spret  <= n_spret;
        r_cont   <= n_cont;
        r_op     <= n_op;
        r_ptr    <= n_ptr;
        r_sz     <= n_sz;
        r_b      <= n_b;
        r_own    <= n_own;
        r_i      <= n_i;
        r_x      <= n_x;
        r_best   <= n_best;
        r_spa    <= n_spa;
        r_spv    <= n_spv;
        r_bsz    <= n_bsz;
        r_old    <= n_old;
        r_found  <= n_found;
        r_lookup <= n_lookup;
        r_move   <= n_move;
        r_hb     <= n_hb;
        r_hx     <= n_hx;
        r_res    <= n_res;
    end

    always_comb begin
        n_st = r_st;  n_spret = r_spret;  n_cont = r_cont;  n_op = r_op;
        n_ptr = r_ptr;  n_sz = r_sz;  n_b = r_b;  n_own = r_own;  n_i = r_i;
        n_x = r_x;  n_best = r_best;  n_spa = r_spa;  n_spv = r_spv;
        n_bsz = r_bsz;  n_old = r_old;  n_found = r_found;  n_lookup = r_lookup;
        n_move = r_move;  n_hb = r_hb;  n_hx = r_hx;  n_res = r_res;
        o_mem = '0;
        o_ready = 1'b0;
        o_done = 1'b0;
        h = i_q;
        eff = (i_arena > REQ_W'(ARENA_BYTES)) ? REQ_W'(ARENA_BYTES) : i_arena;
        eff = {eff[REQ_W-1:2], 2'b00};
        init_sz = (eff >= REQ_W'(HDR_BYTES)) ? eff - REQ_W'(HDR_BYTES) : '0;
        rem = {1'b0, r_hb.size} - r_sz;
        nw = {{(REQ_W+1-IDX_W){1'b0}}, r_b} + (REQ_W+1)'(({1'b0, r_sz} + (REQ_W+1)'(HDR_BYTES)) >> 2);
        sum = '0;
        cand = !i_q.used && ({1'b0, i_q.size} >= r_sz) && (!r_found || i_q.size < r_bsz);
        nf = r_found | cand;
        nb = cand ? r_i : r_best;

        unique case (r_st)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_op = i_op;
                    n_ptr = i_ptr;
                    n_sz = round_size(i_req);
                    n_own = IDX_W'((i_ptr - OFS_W'(HDR_BYTES)) >> 2);
                    n_move = 1'b0;
                    n_res = '0;
                    n_cont = C_DONE;
                    n_i = '0;
                    n_found = 1'b0;
                    o_mem.raddr = '0;
                    unique case (i_op)
                        OP_INIT: begin
                            n_st = S_INIT;
                        end
                        OP_ALLOC: begin
                            n_lookup = 1'b0;
                            n_st = S_WALK;
                        end
                        OP_FREE, OP_RESIZE: begin
                            if (i_ptr == '0) begin
                                n_lookup = 1'b0;
                                n_st = (i_op == OP_FREE) ? S_DONE : S_WALK;
                            end else if (i_ptr < OFS_W'(HDR_BYTES) || i_ptr[1:0] != 2'b00) begin
                                n_res.status = (i_op == OP_RESIZE);
                                n_st = S_DONE;
                            end else begin
                                n_lookup = 1'b1;
                                n_st = S_WALK;
                            end
                        end
                        default: n_st = S_IDLE;
                    endcase
                end
            end
            S_WALK: begin
                if (r_lookup) begin
                    if (r_i == r_own) begin
                        if (!i_q.used) begin
                            n_res.status = (r_op == OP_RESIZE);
                            n_st = S_DONE;
                        end else if (r_op == OP_FREE) begin
                            o_mem.raddr = r_own;
                            n_st = S_FR_B;
                        end else if (r_sz == '0) begin
                            n_cont = C_ALLOC;
                            o_mem.raddr = r_own;
                            n_st = S_FR_B;
                        end else begin
                            n_hb = i_q;
                            n_b = r_own;
                            if ({1'b0, i_q.size} >= r_sz) begin
                                n_res.result_offset = r_ptr;
                                n_st = S_SPL;
                            end else if (i_q.has_next) begin
                                o_mem.raddr = i_q.next;
                                n_st = S_RZ_N;
                            end else begin
                                n_old = i_q.size;
                                n_move = 1'b1;
                                n_st = S_AL_ST;
                            end
                        end
                    end else if (!i_q.has_next) begin
                        n_res.status = (r_op == OP_RESIZE);
                        n_st = S_DONE;
                    end else begin
                        o_mem.raddr = i_q.next;
                        n_i = i_q.next;
                    end
                end else begin
                    n_found = nf;
                    n_best = nb;
                    if (cand) begin
                        n_bsz = i_q.size;
                    end
                    if (i_q.has_next) begin
                        o_mem.raddr = i_q.next;
                        n_i = i_q.next;
                    end else if (nf) begin
                        o_mem.raddr = nb;
                        n_st = S_AL_LD;
                    end else if (r_move && r_hb.has_prev) begin
                        o_mem.raddr = r_hb.prev;
                        n_st = S_RZ_P;
                    end else begin
                        n_res.status = 1'b1;
                        n_st = S_DONE;
                    end
                end
            end
            S_AL_ST: begin
                o_mem.raddr = '0;
                n_i = '0;
                n_found = 1'b0;
                n_lookup = 1'b0;
                n_st = S_WALK;
            end
            S_AL_LD: begin
                h.used = 1'b1;
                n_hb = h;
                n_b = r_best;
                n_res.result_offset = {r_best, 2'b00} + OFS_W'(HDR_BYTES);
                if (r_move) begin
                    n_res.moved = 1'b1;
                    n_res.copy_bytes = r_old;
                    n_cont = C_FREE;
                end else begin
                    n_cont = C_DONE;
                end
                n_st = S_SPL;
            end
            S_RZ_N: begin
                sum = {2'b00, r_hb.size} + {2'b00, i_q.size} + (REQ_W+1)'(HDR_BYTES);
                if (!i_q.used && sum >= {1'b0, r_sz}) begin
                    h = r_hb;
                    h.size = SZ_W'(sum);
                    h.next = i_q.next;
                    h.has_next = i_q.has_next;
                    n_hb = h;
                    n_res.result_offset = r_ptr;
                    if (i_q.has_next) begin
                        o_mem.raddr = i_q.next;
                        n_spa = i_q.next;
                        n_spv = r_b;
                        n_spret = S_SPL;
                        n_st = S_SP_WR;
                    end else begin
                        n_st = S_SPL;
                    end
                end else begin
                    n_old = r_hb.size;
                    n_move = 1'b1;
                    n_st = S_AL_ST;
                end
            end
            S_RZ_P: begin
                sum = {2'b00, r_old} + {2'b00, i_q.size} + (REQ_W+1)'(HDR_BYTES);
                if (!i_q.used && sum >= {1'b0, r_sz}) begin
                    h.size = SZ_W'(sum);
                    h.next = r_hb.next;
                    h.has_next = r_hb.has_next;
                    h.used = 1'b1;
                    n_hb = h;
                    n_b = r_hb.prev;
                    n_res.result_offset = {r_hb.prev, 2'b00} + OFS_W'(HDR_BYTES);
                    n_res.moved = 1'b1;
                    n_res.copy_bytes = r_old;
                    n_cont = C_DONE;
                    if (r_hb.has_next) begin
                        o_mem.raddr = r_hb.next;
                        n_spa = r_hb.next;
                        n_spv = r_hb.prev;
                        n_spret = S_SPL;
                        n_st = S_SP_WR;
                    end else begin
                        n_st = S_SPL;
                    end
                end else begin
                    n_res.status = 1'b1;
                    n_st = S_DONE;
                end
            end
            S_FR_B: begin
                h.used = 1'b0;
                n_hb = h;
                n_b = r_own;
                if (i_q.has_prev) begin
                    o_mem.raddr = i_q.prev;
                    n_st = S_FR_P;
                end else begin
                    n_st = S_FR_NX;
                end
            end
            S_FR_P: begin
                n_st = S_FR_NX;
                if (!i_q.used) begin
                    h.size = i_q.size + r_hb.size + SZ_W'(HDR_BYTES);
                    h.next = r_hb.next;
                    h.has_next = r_hb.has_next;
                    n_hb = h;
                    n_b = r_hb.prev;
                    if (r_hb.has_next) begin
                        o_mem.raddr = r_hb.next;
                        n_spa = r_hb.next;
                        n_spv = r_hb.prev;
                        n_spret = S_FR_NX;
                        n_st = S_SP_WR;
                    end
                end
            end
            S_FR_NX: begin
                if (r_hb.has_next) begin
                    o_mem.raddr = r_hb.next;
                    n_st = S_FR_N;
                end else begin
                    n_st = S_FR_WR;
                end
            end
            S_FR_N: begin
                n_st = S_FR_WR;
                if (!i_q.used) begin
                    h = r_hb;
                    h.size = r_hb.size + i_q.size + SZ_W'(HDR_BYTES);
                    h.next = i_q.next;
                    h.has_next = i_q.has_next;
                    n_hb = h;
                    if (i_q.has_next) begin
                        o_mem.raddr = i_q.next;
                        n_spa = i_q.next;
                        n_spv = r_b;
                        n_spret = S_FR_WR;
                        n_st = S_SP_WR;
                    end
                end
            end
            S_FR_WR: begin
                o_mem.we = 1'b1;
                o_mem.waddr = r_b;
                o_mem.wdata = r_hb;
                n_st = S_CONT;
            end
            S_SPL: begin
                o_mem.we = 1'b1;
                o_mem.waddr = r_b;
                if ({1'b0, r_hb.size} < r_sz || rem <= REQ_W'(HDR_BYTES)
                        || nw >= (REQ_W+1)'(DEPTH)) begin
                    o_mem.wdata = r_hb;
                    n_st = S_CONT;
                end else begin
                    h.size = SZ_W'(rem - REQ_W'(HDR_BYTES));
                    h.used = 1'b0;
                    h.prev = r_b;
                    h.has_prev = 1'b1;
                    h.next = r_hb.next;
                    h.has_next = r_hb.has_next;
                    n_hx = h;
                    n_x = nw[IDX_W-1:0];
                    h = r_hb;
                    h.size = r_sz[SZ_W-1:0];
                    h.next = nw[IDX_W-1:0];
                    h.has_next = 1'b1;
                    o_mem.wdata = h;
                    if (r_hb.has_next) begin
                        o_mem.raddr = r_hb.next;
                        n_st = S_SPL_F;
                    end else begin
                        n_st = S_SPL_WN;
                    end
                end
            end
            S_SPL_F: begin
                n_st = S_SPL_WN;
                if (i_q.used) begin
                    h.prev = r_x;
                    o_mem.we = 1'b1;
                    o_mem.waddr = r_hx.next;
                    o_mem.wdata = h;
                end else begin
                    h = r_hx;
                    h.size = r_hx.size + i_q.size + SZ_W'(HDR_BYTES);
                    h.next = i_q.next;
                    h.has_next = i_q.has_next;
                    n_hx = h;
                    if (i_q.has_next) begin
                        o_mem.raddr = i_q.next;
                        n_spa = i_q.next;
                        n_spv = r_x;
                        n_spret = S_SPL_WN;
                        n_st = S_SP_WR;
                    end
                end
            end
            S_SPL_WN: begin
                o_mem.we = 1'b1;
                o_mem.waddr = r_x;
                o_mem.wdata = r_hx;
                n_st = S_CONT;
            end
            S_SP_WR: begin
                h.prev = r_spv;
                o_mem.we = 1'b1;
                o_mem.waddr = r_spa;
                o_mem.wdata = h;
                n_st = r_spret;
            end
            S_INIT: begin
                h = '0;
                h.size = init_sz[SZ_W-1:0];
                o_mem.we = 1'b1;
                o_mem.waddr = '0;
                o_mem.wdata = h;
                n_st = S_DONE;
            end
            S_CONT: begin
                unique case (r_cont)
                    C_ALLOC: begin
                        n_cont = C_DONE;
                        n_move = 1'b0;
                        n_st = S_AL_ST;
                    end
                    C_FREE: begin
                        n_cont = C_DONE;
                        o_mem.raddr = r_own;
                        n_st = S_FR_B;
                    end
                    default: n_st = S_DONE;
                endcase
            end
            S_DONE: begin
                o_done = 1'b1;
                if (i_out_free) begin
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    assign o_res = r_res;

endmodule

FILE: design/best_fit_heap_allocator_unit.sv
// Best-fit heap allocator over an arena of up to 64 KiB, with block headers held in a
// single-port-write memory of 16384 words with a registered read. An allocate
// walks the whole block chain, one header per cycle; release and resize first walk
// the chain up to the named block and then do neighbor merges and splits, and a resize
// that has to move adds a full allocation walk. Issue an initialize before any other
// word; results come out in order through one output register, and a new request
// word is taken while the previous result waits there.
module best_fit_heap_allocator_unit (
    input logic       i_clk,
    input logic       i_rst_n,
    bfha_req_if.sink  i_req,
    bfha_rsp_if.source o_rsp,
    bfha_cfg_if.sink  i_cfg
);
    import bfha_pkg::*;

    logic [REQ_W-1:0] r_arena;
    logic             r_out_vld;
    t_res             r_out;
    t_mem_req         mem_req;
    t_hdr             mem_q;
    logic             seq_done;
    t_res             seq_res;
    logic             out_free;

    assign out_free = !r_out_vld || o_rsp.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arena   <= REQ_W'(ARENA_BYTES);
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_arena <= i_cfg.arena_bytes;
            end
            if (seq_done && out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
        if (seq_done && out_free) begin
            r_out <= seq_res;
        end
    end

    bfha_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_req.valid),
        .o_ready    (i_req.ready),
        .i_op       (t_op'(i_req.operation)),
        .i_ptr      (i_req.payload_offset),
        .i_req      (i_req.request_bytes),
        .i_arena    (r_arena),
        .o_mem      (mem_req),
        .i_q        (mem_q),
        .o_done     (seq_done),
        .o_res      (seq_res),
        .i_out_free (out_free)
    );

    bfha_hdr_mem u_mem (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_q   (mem_q)
    );

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.status        = r_out.status;
    assign o_rsp.result_offset = r_out.result_offset;
    assign o_rsp.moved         = r_out.moved;
    assign o_rsp.copy_bytes    = r_out.copy_bytes;

    a_fail_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.status |-> o_rsp.result_offset == '0 && !o_rsp.moved)
        else $error("failed request carries an offset or a move");

    a_copy_only_moved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.moved |-> o_rsp.copy_bytes == '0)
        else $error("copy length without a move");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_done && out_free |=> r_out_vld)
        else $error("finished result not registered");

endmodule
